/* rtl/sirt_pkg.sv */
`default_nettype none

package sirt_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam int WORD_CHARS = CFG_DATA_W / CHAR_W;

    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int BUF_DEPTH = VALUE_W;
    localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
    localparam int ND_W      = BUF_IDX_W + 1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_first;
        logic div_last;
        logic emit_sign;
        logic emit_digit;
    } sirt_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic quot_zero;
        logic out_free;
        logic nd_one;
    } sirt_status_t;

endpackage

`default_nettype wire

/* rtl/sirt_ctrl.sv */
`default_nettype none

module sirt_ctrl
    import sirt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output sirt_cmd_t         cmd,
    input  wire sirt_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] step_cnt_reg;
    logic [DIV_CNT_W-1:0] step_cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                step_cnt_next = '0;
                state_next    = status.alpha_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_cnt_reg == '0);
                cmd.div_last  = (step_cnt_reg == STEP_LAST);
                step_cnt_next = step_cnt_reg + DIV_CNT_W'(1);
                if (cmd.div_last)
                begin
                    step_cnt_next = '0;
                    if (status.quot_zero)
                    begin
                        state_next = status.neg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.nd_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // An accepted number is always followed by the alphabet check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_CHECK))
        else $error("accepted number did not enter the alphabet check");

    // An invalid alphabet returns to idle without emitting anything.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !status.alpha_ok) |=> (state_reg == ST_IDLE))
        else $error("invalid alphabet did not return to idle");

    // A digit division is never cut short before its last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_cnt_reg != STEP_LAST) |=> (state_reg == ST_DIV))
        else $error("division left before its last step");

endmodule

`default_nettype wire

/* rtl/sirt_dp.sv */
`default_nettype none

module sirt_dp
    import sirt_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [CHAR_W-1:0]          out_char,
    output logic                       last,
    input  wire sirt_cmd_t             cmd,
    output sirt_status_t               status
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [CHAR_W-1:0]  digit_reg [MAX_DIGITS];
    logic [COUNT_W-1:0] count_reg;
    logic               alpha_ok_reg;
    logic               alpha_ok_next;

    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] mag_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic               neg_reg;
    logic [ND_W-1:0]    nd_reg;
    logic [ND_W-1:0]    nd_dec;
    logic [IDX_W-1:0]   buf_reg [BUF_DEPTH];

    logic [CHAR_W-1:0]  out_char_reg;
    logic               last_reg;
    logic               out_valid_reg;

    logic [VALUE_W-1:0] value_u;
    logic [VALUE_W-1:0] mag_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_DIGITS_LOW)
            begin
                for (int i = 0; i < WORD_CHARS && i < MAX_DIGITS; i++)
                begin
                    digit_reg[i] <= cfg_data[CHAR_W*i +: CHAR_W];
                end
            end
            if (cfg_index == REG_DIGITS_HIGH)
            begin
                for (int i = WORD_CHARS; i < MAX_DIGITS; i++)
                begin
                    digit_reg[i] <= cfg_data[CHAR_W*(i-WORD_CHARS) +: CHAR_W];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            alpha_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_DIGIT_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            alpha_ok_reg <= alpha_ok_next;
        end
    end

    // The alphabet needs from two to MAX_DIGITS digits, none of them a sign or NUL, and no repeats.
    always_comb
    begin
        alpha_ok_next = (count_reg >= COUNT_W'(2)) && (count_reg <= COUNT_W'(MAX_DIGITS));
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (COUNT_W'(i) < count_reg)
            begin
                if (digit_reg[i] == CHAR_NUL || digit_reg[i] == CHAR_PLUS ||
                    digit_reg[i] == CHAR_MINUS)
                begin
                    alpha_ok_next = 1'b0;
                end
                for (int j = 0; j < i; j++)
                begin
                    if (digit_reg[j] == digit_reg[i])
                    begin
                        alpha_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    assign value_u  = $unsigned(value);
    assign mag_load = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;

    // Restoring division of the magnitude by the radix, several quotient bits per cycle.
    always_comb
    begin
        logic [COUNT_W-1:0] trial;
        trial    = '0;
        rem_next = cmd.div_first ? '0 : rem_reg;
        mag_next = mag_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial    = {rem_next[COUNT_W-2:0], mag_next[VALUE_W-1]};
            mag_next = {mag_next[VALUE_W-2:0], 1'b0};
            if (trial >= count_reg)
            begin
                rem_next    = trial - count_reg;
                mag_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    assign nd_dec = nd_reg - ND_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag_load;
            neg_reg <= value_u[VALUE_W-1];
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
        if (cmd.div_last)
        begin
            buf_reg[nd_reg[BUF_IDX_W-1:0]] <= rem_next[IDX_W-1:0];
        end
        if (cmd.emit_sign)
        begin
            out_char_reg <= CHAR_MINUS;
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= digit_reg[buf_reg[nd_dec[BUF_IDX_W-1:0]]];
            last_reg     <= (nd_reg == ND_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd.load)
            begin
                nd_reg <= '0;
            end
            else if (cmd.div_last)
            begin
                nd_reg <= nd_reg + ND_W'(1);
            end
            else if (cmd.emit_digit)
            begin
                nd_reg <= nd_dec;
            end
            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    assign status.alpha_ok  = alpha_ok_reg;
    assign status.neg       = neg_reg;
    assign status.quot_zero = (mag_next == '0);
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.nd_one    = (nd_reg == ND_W'(1));

    // Each finished digit leaves a remainder below the radix.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_last |=> (rem_reg < count_reg))
        else $error("remainder not below the radix after a digit");

    // A digit is only emitted while the buffer still holds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (nd_reg != '0))
        else $error("digit emitted from an empty buffer");

endmodule

`default_nettype wire

/* rtl/signed_int_to_radix_text.sv */
// Sequence: the number is accepted, the alphabet is checked, each digit is found in the
// eight-bit-per-cycle divider, then a minus sign if negative and the digits leave through
// the output register, one character per cycle when the output is not stalled.
// No new number is taken until the last character of the item has been emitted.
// An invalid alphabet ends the item after the check with no transfer on the output.
// Reset clears the alphabet and digit count, so no text is produced until configured.
`default_nettype none

module signed_int_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [CHAR_W-1:0]              out_char,
    output logic                           last
);

    sirt_cmd_t    cmd;
    sirt_status_t status;

    sirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    sirt_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
